@@ src/gne_pkg.sv @@
`timescale 1ns / 1ps
package gne_pkg;

   localparam int MAX_AXES    = 3;
   localparam int AXIS_BITS   = 10;
   localparam int SIZE_BITS   = AXIS_BITS + 1;
   localparam int PLANE_BITS  = 2 * AXIS_BITS + 1;
   localparam int FLAT_BITS   = MAX_AXES * AXIS_BITS;
   localparam int SPAN_BITS   = 2;
   localparam int EXT2_BITS   = 2 * SPAN_BITS;
   localparam int COUNT_BITS  = 5;
   localparam int AXES_BITS   = 2;
   localparam int CSR_BITS    = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;

   localparam logic [SIZE_BITS-1:0] SIZE_CAP = SIZE_BITS'(1 << AXIS_BITS);
   localparam logic [AXES_BITS-1:0] AXES_RESET = AXES_BITS'(MAX_AXES);

   typedef enum logic [CSR_BITS-1:0] {
      CSR_AXES        = 2'd0,
      CSR_SIZE_FIRST  = 2'd1,
      CSR_SIZE_SECOND = 2'd2,
      CSR_SIZE_THIRD  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_SCALE,
      FRONT_OFFSET,
      FRONT_ISSUE
   } front_state_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_WALK
   } back_state_type;

   typedef logic [MAX_AXES-1:0][AXIS_BITS-1:0] axis_vec_type;

   typedef struct packed {
      logic [AXES_BITS-1:0]                axes;
      logic [MAX_AXES-1:0][SIZE_BITS-1:0]  sizes;
   } cfg_type;

   // one cube walk handed from the front to the back
   typedef struct packed {
      axis_vec_type            lo;
      axis_vec_type            hi;
      axis_vec_type            centre;
      logic [SIZE_BITS-1:0]    stride1;
      logic [PLANE_BITS-1:0]   delta2;
      logic [FLAT_BITS-1:0]    row0;
      logic [COUNT_BITS-1:0]   count;
   } job_type;

   function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] raw,
                                                     input logic used);
      logic [SIZE_BITS-1:0] s;
      if (!used || raw == '0) begin
         s = SIZE_BITS'(1);
      end else if (raw > SIZE_CAP) begin
         s = SIZE_CAP;
      end else begin
         s = raw;
      end
      return s;
   endfunction

endpackage

@@ src/gne_front.sv @@
`timescale 1ns / 1ps
module gne_front (
   input  logic                   clock,
   input  logic                   reset,
   input  gne_pkg::cfg_type       cfg,
   input  logic                   push,
   output logic                   full,
   input  gne_pkg::axis_vec_type  centre,
   input  logic                   reach,
   output logic                   q_push,
   input  logic                   q_full,
   output gne_pkg::job_type       q_data
);

   gne_pkg::front_state_type state_ff, state_in;

   gne_pkg::axis_vec_type lo_ff, lo_in, hi_ff, hi_in, c_ff, c_in;
   logic [gne_pkg::SIZE_BITS-1:0]  s0_ff, s0_in, s1_ff, s1_in;
   logic [gne_pkg::PLANE_BITS-1:0] s01_ff, s01_in, lo1s0_ff, lo1s0_in;
   logic [gne_pkg::PLANE_BITS-1:0] delta2_ff, delta2_in;
   logic [gne_pkg::SIZE_BITS+1:0]  span1s0_ff, span1s0_in;
   logic [gne_pkg::FLAT_BITS-1:0]  lo2s01_ff, lo2s01_in;
   logic [gne_pkg::EXT2_BITS-1:0]  e01_ff, e01_in;
   logic [gne_pkg::COUNT_BITS-1:0] count_ff, count_in;

   logic                            accept;
   logic [gne_pkg::AXES_BITS-1:0]  n_eff;
   logic [gne_pkg::SIZE_BITS-1:0]  sz   [gne_pkg::MAX_AXES];
   logic [gne_pkg::SIZE_BITS-1:0]  lim  [gne_pkg::MAX_AXES];
   logic [gne_pkg::SIZE_BITS-1:0]  craw [gne_pkg::MAX_AXES];
   logic [gne_pkg::SIZE_BITS-1:0]  cc   [gne_pkg::MAX_AXES];
   logic [gne_pkg::SIZE_BITS-1:0]  up   [gne_pkg::MAX_AXES];
   logic [gne_pkg::SIZE_BITS-1:0]  dn   [gne_pkg::MAX_AXES];
   logic [gne_pkg::SIZE_BITS-1:0]  r11;
   logic [gne_pkg::SPAN_BITS-1:0]  ext  [gne_pkg::MAX_AXES];
   logic [gne_pkg::SPAN_BITS-1:0]  span1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gne_pkg::FRONT_IDLE:   if (push) state_in = gne_pkg::FRONT_SCALE;
         gne_pkg::FRONT_SCALE:  state_in = gne_pkg::FRONT_OFFSET;
         gne_pkg::FRONT_OFFSET: state_in = gne_pkg::FRONT_ISSUE;
         gne_pkg::FRONT_ISSUE: begin
            if (count_ff == '0 || !q_full) state_in = gne_pkg::FRONT_IDLE;
         end
         default:               state_in = gne_pkg::FRONT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      full   = (state_ff != gne_pkg::FRONT_IDLE);
      accept = (state_ff == gne_pkg::FRONT_IDLE) && push;
      q_push = (state_ff == gne_pkg::FRONT_ISSUE) && (count_ff != '0) && !q_full;
   end

   // clamp the centre and the cube to the grid
   always_comb begin
      n_eff = (cfg.axes == '0) ? gne_pkg::AXES_BITS'(1) : cfg.axes;
      r11   = gne_pkg::SIZE_BITS'(reach);
      for (int d = 0; d < gne_pkg::MAX_AXES; d++) begin
         sz[d]   = gne_pkg::eff_size(cfg.sizes[d], d < int'(n_eff));
         lim[d]  = sz[d] - gne_pkg::SIZE_BITS'(1);
         craw[d] = (d < int'(n_eff)) ? gne_pkg::SIZE_BITS'(centre[d]) : '0;
         cc[d]   = (craw[d] > lim[d]) ? lim[d] : craw[d];
         up[d]   = cc[d] + r11;
         dn[d]   = (cc[d] >= r11) ? (cc[d] - r11) : '0;
         c_in[d]  = accept ? cc[d][gne_pkg::AXIS_BITS-1:0] : c_ff[d];
         lo_in[d] = accept ? dn[d][gne_pkg::AXIS_BITS-1:0] : lo_ff[d];
         hi_in[d] = accept ? ((up[d] > lim[d]) ? lim[d][gne_pkg::AXIS_BITS-1:0]
                                               : up[d][gne_pkg::AXIS_BITS-1:0])
                           : hi_ff[d];
         ext[d]  = gne_pkg::SPAN_BITS'(hi_ff[d] - lo_ff[d]) + gne_pkg::SPAN_BITS'(1);
      end
      s0_in = accept ? sz[0] : s0_ff;
      s1_in = accept ? sz[1] : s1_ff;
   end

   // strides and offsets in the scale and offset states
   always_comb begin
      span1      = gne_pkg::SPAN_BITS'(hi_ff[1] - lo_ff[1]);
      s01_in     = s01_ff;
      lo1s0_in   = lo1s0_ff;
      span1s0_in = span1s0_ff;
      e01_in     = e01_ff;
      lo2s01_in  = lo2s01_ff;
      delta2_in  = delta2_ff;
      count_in   = count_ff;
      if (state_ff == gne_pkg::FRONT_SCALE) begin
         s01_in     = gne_pkg::PLANE_BITS'(s0_ff) * gne_pkg::PLANE_BITS'(s1_ff);
         lo1s0_in   = gne_pkg::PLANE_BITS'(lo_ff[1]) * gne_pkg::PLANE_BITS'(s0_ff);
         span1s0_in = (gne_pkg::SIZE_BITS+2)'(span1) * (gne_pkg::SIZE_BITS+2)'(s0_ff);
         e01_in     = gne_pkg::EXT2_BITS'(ext[0]) * gne_pkg::EXT2_BITS'(ext[1]);
      end
      if (state_ff == gne_pkg::FRONT_OFFSET) begin
         lo2s01_in = gne_pkg::FLAT_BITS'(lo_ff[2]) * gne_pkg::FLAT_BITS'(s01_ff);
         delta2_in = s01_ff - gne_pkg::PLANE_BITS'(span1s0_ff);
         count_in  = gne_pkg::COUNT_BITS'(e01_ff) * gne_pkg::COUNT_BITS'(ext[2])
                   - gne_pkg::COUNT_BITS'(1);
      end
   end

   always_comb begin
      q_data.lo      = lo_ff;
      q_data.hi      = hi_ff;
      q_data.centre  = c_ff;
      q_data.stride1 = s0_ff;
      q_data.delta2  = delta2_ff;
      q_data.row0    = lo2s01_ff + gne_pkg::FLAT_BITS'(lo1s0_ff);
      q_data.count   = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gne_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      c_ff       <= c_in;
      s0_ff      <= s0_in;
      s1_ff      <= s1_in;
      s01_ff     <= s01_in;
      lo1s0_ff   <= lo1s0_in;
      span1s0_ff <= span1s0_in;
      e01_ff     <= e01_in;
      lo2s01_ff  <= lo2s01_in;
      delta2_ff  <= delta2_in;
      count_ff   <= count_in;
   end

endmodule

@@ src/gne_queue.sv @@
`timescale 1ns / 1ps
module gne_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  gne_pkg::job_type  wr_data,
   output logic              q_full,
   input  logic              rd_en,
   output gne_pkg::job_type  rd_data,
   output logic              q_empty
);

   gne_pkg::job_type                entry_ff [gne_pkg::QUEUE_DEPTH];
   logic [gne_pkg::QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [gne_pkg::QPTR_BITS:0]    fill_ff, fill_in;
   logic                            do_wr, do_rd;

   always_comb begin
      q_full    = (fill_ff == (gne_pkg::QPTR_BITS+1)'(gne_pkg::QUEUE_DEPTH));
      q_empty   = (fill_ff == '0);
      do_wr     = wr_en && !q_full;
      do_rd     = rd_en && !q_empty;
      wr_ptr_in = do_wr ? wr_ptr_ff + gne_pkg::QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + gne_pkg::QPTR_BITS'(1) : rd_ptr_ff;
      fill_in   = fill_ff + (gne_pkg::QPTR_BITS+1)'(do_wr)
                          - (gne_pkg::QPTR_BITS+1)'(do_rd);
      rd_data   = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ src/gne_back.sv @@
`timescale 1ns / 1ps
module gne_back (
   input  logic                                clock,
   input  logic                                reset,
   input  gne_pkg::job_type                    job,
   input  logic                                q_empty,
   output logic                                q_pop,
   output logic                                empty,
   input  logic                                pop,
   output logic [gne_pkg::FLAT_BITS-1:0]       flat_node,
   output logic                                final_one
);

   gne_pkg::back_state_type state_ff, state_in;

   gne_pkg::axis_vec_type lo_ff, lo_in, hi_ff, hi_in, c_ff, c_in, pos_ff, pos_in;
   logic [gne_pkg::SIZE_BITS-1:0]  s0_ff, s0_in;
   logic [gne_pkg::PLANE_BITS-1:0] delta2_ff, delta2_in;
   logic [gne_pkg::FLAT_BITS-1:0]  row_ff, row_in;
   logic [gne_pkg::COUNT_BITS-1:0] left_ff, left_in;
   logic                            out_valid_ff, out_valid_in;
   logic [gne_pkg::FLAT_BITS-1:0]  out_flat_ff, out_flat_in;
   logic                            out_final_ff, out_final_in;

   logic walking, is_centre, out_free, step, emit, last_emit;

   always_comb begin
      is_centre = (pos_ff == c_ff);
      out_free  = !out_valid_ff || pop;
      walking   = (state_ff == gne_pkg::BACK_WALK);
      step      = walking && (is_centre || out_free);
      emit      = step && !is_centre;
      last_emit = emit && (left_ff == gne_pkg::COUNT_BITS'(1));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gne_pkg::BACK_IDLE: if (!q_empty) state_in = gne_pkg::BACK_WALK;
         gne_pkg::BACK_WALK: if (last_emit) state_in = gne_pkg::BACK_IDLE;
         default:            state_in = gne_pkg::BACK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop     = (state_ff == gne_pkg::BACK_IDLE) && !q_empty;
      empty     = !out_valid_ff;
      flat_node = out_flat_ff;
      final_one = out_final_ff;
   end

   // walk the cube, first axis fastest; row holds i1*s0 + i2*s0*s1
   always_comb begin
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      c_in      = c_ff;
      s0_in     = s0_ff;
      delta2_in = delta2_ff;
      pos_in    = pos_ff;
      row_in    = row_ff;
      left_in   = left_ff;
      if (q_pop) begin
         lo_in     = job.lo;
         hi_in     = job.hi;
         c_in      = job.centre;
         s0_in     = job.stride1;
         delta2_in = job.delta2;
         pos_in    = job.lo;
         row_in    = job.row0;
         left_in   = job.count;
      end else if (step) begin
         if (emit) left_in = left_ff - gne_pkg::COUNT_BITS'(1);
         if (pos_ff[0] != hi_ff[0]) begin
            pos_in[0] = pos_ff[0] + gne_pkg::AXIS_BITS'(1);
         end else begin
            pos_in[0] = lo_ff[0];
            if (pos_ff[1] != hi_ff[1]) begin
               pos_in[1] = pos_ff[1] + gne_pkg::AXIS_BITS'(1);
               row_in    = row_ff + gne_pkg::FLAT_BITS'(s0_ff);
            end else begin
               pos_in[1] = lo_ff[1];
               pos_in[2] = pos_ff[2] + gne_pkg::AXIS_BITS'(1);
               row_in    = row_ff + gne_pkg::FLAT_BITS'(delta2_ff);
            end
         end
      end
   end

   // result register: hold until popped
   always_comb begin
      out_valid_in = out_valid_ff;
      out_flat_in  = out_flat_ff;
      out_final_in = out_final_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_flat_in  = row_ff + gne_pkg::FLAT_BITS'(pos_ff[0]);
         out_final_in = last_emit;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gne_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      c_ff         <= c_in;
      s0_ff        <= s0_in;
      delta2_ff    <= delta2_in;
      pos_ff       <= pos_in;
      row_ff       <= row_in;
      left_ff      <= left_in;
      out_flat_ff  <= out_flat_in;
      out_final_ff <= out_final_in;
   end

endmodule

@@ src/grid_neighbourhood_enumerator.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req       in         push / full          req_centre_first/second/third, req_reach
// rsp       out        empty / pop          rsp_flat_node, rsp_final_one
// csr       in         csr_valid/csr_ready  csr_index, csr_data
//
// The front takes a request only while idle, clamps the cube on acceptance, forms
// strides and offsets in its scale and offset states and issues the job to the
// queue; the back loads a job in its idle state, then walks one cube position per
// cycle while no result is held, so a full radius-one 3D request gives 26 results
// and steps over the centre slot. Reset is synchronous and needs no clearing pass.
// A held result stalls the walk until popped; the front stalls when the queue is full.
module grid_neighbourhood_enumerator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [gne_pkg::AXIS_BITS-1:0]      req_centre_first,
   input  logic [gne_pkg::AXIS_BITS-1:0]      req_centre_second,
   input  logic [gne_pkg::AXIS_BITS-1:0]      req_centre_third,
   input  logic                               req_reach,
   output logic                               empty,
   input  logic                               pop,
   output logic [gne_pkg::FLAT_BITS-1:0]      rsp_flat_node,
   output logic                               rsp_final_one,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gne_pkg::CSR_BITS-1:0]       csr_index,
   input  logic [gne_pkg::SIZE_BITS-1:0]      csr_data
);

   gne_pkg::cfg_type       cfg_ff, cfg_in;
   gne_pkg::axis_vec_type  centre;
   gne_pkg::job_type       push_job, pop_job;
   logic                   q_push, q_full, q_pop, q_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (gne_pkg::csr_index_type'(csr_index))
            gne_pkg::CSR_AXES:        cfg_in.axes     = csr_data[gne_pkg::AXES_BITS-1:0];
            gne_pkg::CSR_SIZE_FIRST:  cfg_in.sizes[0] = csr_data;
            gne_pkg::CSR_SIZE_SECOND: cfg_in.sizes[1] = csr_data;
            gne_pkg::CSR_SIZE_THIRD:  cfg_in.sizes[2] = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axes  <= gne_pkg::AXES_RESET;
         cfg_ff.sizes <= {gne_pkg::MAX_AXES{gne_pkg::SIZE_CAP}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign centre = {req_centre_third, req_centre_second, req_centre_first};

   gne_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .push   (push),
      .full   (full),
      .centre (centre),
      .reach  (req_reach),
      .q_push (q_push),
      .q_full (q_full),
      .q_data (push_job)
   );

   gne_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (push_job),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_data (pop_job),
      .q_empty (q_empty)
   );

   gne_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (pop_job),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .empty     (empty),
      .pop       (pop),
      .flat_node (rsp_flat_node),
      .final_one (rsp_final_one)
   );

endmodule
